FILE: sv/linear_probe_hash_table_assert.svh
// Assertion macros for the linear probing hash table.
// Used by linear_probe_hash_table; every check is clocked by clock and held off in reset.
`ifndef LINEAR_PROBE_HASH_TABLE_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_ASSERT_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define LPHT_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LPHT_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define LPHT_ASSERT_IMP(name, ante, cons)
`define LPHT_ASSERT_NEXT(name, ante, cons)

`endif

`endif

FILE: sv/lpht_pkg.sv
// Shared constants, codes and types of the linear probing hash table.
// Used by lpht_slot_ram and linear_probe_hash_table; depends on nothing.
`default_nettype none

package lpht_pkg;

   localparam int TABLE_SLOTS = 32;
   localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int CNT_W       = SLOT_W + 1;
   localparam int KEY_W       = 16;
   localparam int VALUE_W     = 32;
   localparam int PORT_SLOT_W = 5;

   // Reciprocal for the home slot: key * RECIP >> 32 is the quotient or one below it.
   localparam logic [63:0] RECIP_WIDE = (64'd1 << 32) / TABLE_SLOTS;
   localparam logic [31:0] RECIP      = RECIP_WIDE[31:0];

   localparam logic [1:0] OP_SEARCH = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;
   localparam logic [1:0] OP_NONE   = 2'd3;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;

   typedef struct packed {
      logic                     en;
      logic [SLOT_W-1:0]        addr;
      logic [KEY_W-1:0]         key;
      logic signed [VALUE_W-1:0] value;
   } lpht_wr_type;

   typedef struct packed {
      logic [KEY_W-1:0]         key;
      logic signed [VALUE_W-1:0] value;
   } lpht_rd_type;

   // The slot port carries the low five bits of the slot index.
   function automatic logic [PORT_SLOT_W-1:0] slot_to_port(input logic [SLOT_W-1:0] idx);
      logic [SLOT_W+PORT_SLOT_W-1:0] wide;
      wide = (SLOT_W + PORT_SLOT_W)'(idx);
      return wide[PORT_SLOT_W-1:0];
   endfunction

endpackage

`default_nettype wire

FILE: sv/linear_probe_hash_table.sv
// Hash table with open addressing and linear probing, one word per request.
// A request steps through S_HOME, S_MOD, S_WALK and S_FINISH; the walk ends at a decision
// or after a full pass over the table, and the unused opcode goes straight to S_FINISH.
// One request at a time: the next is taken once the answer is loaded into the response
// registers and the block is back in S_IDLE; loading waits while an answer is not taken.
// Synchronous active-high reset clears all used and tombstone flags at once.
`default_nettype none
`include "linear_probe_hash_table_assert.svh"

module linear_probe_hash_table
   import lpht_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [1:0]                req_opcode,
   input  wire logic [KEY_W-1:0]          req_key,
   input  wire logic signed [VALUE_W-1:0] req_value_in,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [1:0]                     rsp_status,
   output logic signed [VALUE_W-1:0]      rsp_value_out,
   output logic [PORT_SLOT_W-1:0]         rsp_slot
);

   typedef enum logic [2:0] {S_IDLE, S_HOME, S_MOD, S_WALK, S_FINISH} state_type;

   state_type                  state_ff, state_in;
   logic [1:0]                 op_ff, op_in;
   logic [KEY_W-1:0]           key_ff, key_in;
   logic signed [VALUE_W-1:0]  val_ff, val_in;
   logic [KEY_W-1:0]           q_ff, q_in;
   logic [SLOT_W-1:0]          idx_ff, idx_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic [SLOT_W-1:0]          chk_idx_ff, chk_idx_in;
   logic                       chk_vld_ff, chk_vld_in;
   logic [TABLE_SLOTS-1:0]     used_ff, used_in;
   logic [TABLE_SLOTS-1:0]     tomb_ff, tomb_in;
   logic [1:0]                 res_status_ff, res_status_in;
   logic signed [VALUE_W-1:0]  res_value_ff, res_value_in;
   logic [PORT_SLOT_W-1:0]     res_slot_ff, res_slot_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [1:0]                 rsp_status_ff, rsp_status_in;
   logic signed [VALUE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [PORT_SLOT_W-1:0]     rsp_slot_ff, rsp_slot_in;

   lpht_wr_type                wr;
   lpht_rd_type                rd;
   logic [47:0]                prod;
   logic [26:0]                qn;
   logic [KEY_W:0]             rem;
   logic                       chk_empty;
   logic                       chk_match;

   lpht_slot_ram u_ram (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (idx_ff),
      .rd      (rd)
   );

   assign prod      = 48'(key_ff) * 48'(RECIP);
   assign qn        = 27'(q_ff) * 27'(TABLE_SLOTS);
   assign chk_empty = !used_ff[chk_idx_ff] && !tomb_ff[chk_idx_ff];
   assign chk_match = used_ff[chk_idx_ff] && (rd.key == key_ff);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      val_in        = val_ff;
      q_in          = q_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      chk_idx_in    = chk_idx_ff;
      chk_vld_in    = chk_vld_ff;
      used_in       = used_ff;
      tomb_in       = tomb_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      res_slot_in   = res_slot_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_slot_in   = rsp_slot_ff;
      wr            = '0;
      rem           = (KEY_W + 1)'(key_ff) - qn[KEY_W:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in      = req_opcode;
               key_in     = req_key;
               val_in     = req_value_in;
               cnt_in     = '0;
               chk_vld_in = 1'b0;
               if (req_opcode == OP_NONE) begin
                  res_status_in = ST_NOT_FOUND;
                  res_value_in  = '0;
                  res_slot_in   = '0;
                  state_in      = S_FINISH;
               end else begin
                  state_in = S_HOME;
               end
            end
         end
         S_HOME: begin
            q_in     = prod[47:32];
            state_in = S_MOD;
         end
         S_MOD: begin
            // The estimated quotient is at most one low, so one subtraction corrects it.
            if (rem >= (KEY_W + 1)'(TABLE_SLOTS)) begin
               rem = rem - (KEY_W + 1)'(TABLE_SLOTS);
            end
            idx_in   = rem[SLOT_W-1:0];
            state_in = S_WALK;
         end
         S_WALK: begin
            // Slot reads are issued in the cycle before the check of that slot.
            if (cnt_ff < CNT_W'(TABLE_SLOTS)) begin
               chk_vld_in = 1'b1;
               chk_idx_in = idx_ff;
               idx_in     = (idx_ff == SLOT_W'(TABLE_SLOTS - 1)) ? '0 : idx_ff + 1'b1;
               cnt_in     = cnt_ff + 1'b1;
            end else begin
               chk_vld_in = 1'b0;
            end
            if (chk_vld_ff) begin
               if (op_ff == OP_INSERT) begin
                  if (!used_ff[chk_idx_ff]) begin
                     wr.en                = 1'b1;
                     wr.addr              = chk_idx_ff;
                     wr.key               = key_ff;
                     wr.value             = val_ff;
                     used_in[chk_idx_ff]  = 1'b1;
                     tomb_in[chk_idx_ff]  = 1'b0;
                     res_status_in        = ST_OK;
                     res_value_in         = '0;
                     res_slot_in          = slot_to_port(chk_idx_ff);
                     state_in             = S_FINISH;
                  end
               end else if (chk_empty) begin
                  res_status_in = ST_NOT_FOUND;
                  res_value_in  = '0;
                  res_slot_in   = '0;
                  state_in      = S_FINISH;
               end else if (chk_match) begin
                  res_status_in = ST_OK;
                  res_value_in  = rd.value;
                  res_slot_in   = slot_to_port(chk_idx_ff);
                  if (op_ff == OP_DELETE) begin
                     used_in[chk_idx_ff] = 1'b0;
                     tomb_in[chk_idx_ff] = 1'b1;
                  end
                  state_in = S_FINISH;
               end
            end else if (cnt_ff == CNT_W'(TABLE_SLOTS)) begin
               // A full pass went by without a decision.
               res_status_in = (op_ff == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
               res_value_in  = '0;
               res_slot_in   = '0;
               state_in      = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_value_in  = res_value_ff;
               rsp_slot_in   = res_slot_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         chk_vld_ff   <= 1'b0;
         used_ff      <= '0;
         tomb_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         chk_vld_ff    <= chk_vld_in;
         used_ff       <= used_in;
         tomb_ff       <= tomb_in;
         rsp_valid_ff  <= rsp_valid_in;
         op_ff         <= op_in;
         key_ff        <= key_in;
         val_ff        <= val_in;
         q_ff          <= q_in;
         idx_ff        <= idx_in;
         chk_idx_ff    <= chk_idx_in;
         res_status_ff <= res_status_in;
         res_value_ff  <= res_value_in;
         res_slot_ff   <= res_slot_in;
         rsp_status_ff <= rsp_status_in;
         rsp_value_ff  <= rsp_value_in;
         rsp_slot_ff   <= rsp_slot_in;
      end
   end

   assign req_ready     = (state_ff == S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_value_out = rsp_value_ff;
   assign rsp_slot      = rsp_slot_ff;

   `LPHT_ASSERT_IMP(a_flags_exclusive, 1'b1, (used_ff & tomb_ff) == '0)
   `LPHT_ASSERT_IMP(a_probe_bound, 1'b1, cnt_ff <= CNT_W'(TABLE_SLOTS))
   `LPHT_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)
   `LPHT_ASSERT_NEXT(a_insert_marks_used, wr.en, used_ff[$past(wr.addr)] && !tomb_ff[$past(wr.addr)])
   `LPHT_ASSERT_IMP(a_insert_only_walk, wr.en, state_ff == S_WALK && op_ff == OP_INSERT)

endmodule

`default_nettype wire

FILE: sv/lpht_slot_ram.sv
// Key and data storage of the hash table: one write port, one registered read port.
// Depends on lpht_pkg.
`default_nettype none

module lpht_slot_ram
   import lpht_pkg::*;
(
   input  wire logic              clock,
   input  wire lpht_wr_type       wr,
   input  wire logic [SLOT_W-1:0] rd_addr,
   output lpht_rd_type            rd
);

   lpht_rd_type mem [TABLE_SLOTS];
   lpht_rd_type rd_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= '{key: wr.key, value: wr.value};
      end
      rd_ff <= mem[rd_addr];
   end

   assign rd = rd_ff;

endmodule

`default_nettype wire

FILE: dv/lpht_table_checker.sv
// Watches both channels of linear_probe_hash_table, keeps its own copy of the table and
// predicts every answer in acceptance order. Depends on lpht_pkg for widths and codes.
`timescale 1ns / 1ps

module lpht_table_checker
   import lpht_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic [1:0]                req_opcode,
   input  logic [KEY_W-1:0]          req_key,
   input  logic signed [VALUE_W-1:0] req_value_in,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic [1:0]                rsp_status,
   input  logic signed [VALUE_W-1:0] rsp_value_out,
   input  logic [PORT_SLOT_W-1:0]    rsp_slot,
   output int                        fail_count,
   output int                        outstanding,
   output int                        full_count,
   output int                        hit_count
);

   typedef struct packed {
      logic [1:0]                status;
      logic signed [VALUE_W-1:0] value;
      logic [PORT_SLOT_W-1:0]    slot;
   } answer_type;

   bit                        live[TABLE_SLOTS];
   bit                        tomb[TABLE_SLOTS];
   logic [KEY_W-1:0]          slot_keys[TABLE_SLOTS];
   logic signed [VALUE_W-1:0] slot_data[TABLE_SLOTS];

   answer_type answers_due[$];
   answer_type want;
   int         errors;
   int         fulls;
   int         hits;
   int         words_back;

   task automatic report_mismatch(input string msg);
      errors++;
      $display("%0t ns: mismatch on answer word %0d: %s", $time, words_back, msg);
   endtask

   // Walks from the home slot until the key or an empty slot; tombstones are stepped over.
   function automatic bit find_live_slot(input logic [KEY_W-1:0] k, output int idx);
      int s;
      idx = 0;
      s = int'(k) % TABLE_SLOTS;
      for (int n = 0; n < TABLE_SLOTS; n++) begin
         if (!live[s] && !tomb[s])
            return 1'b0;
         if (live[s] && slot_keys[s] == k) begin
            idx = s;
            return 1'b1;
         end
         s = (s + 1 == TABLE_SLOTS) ? 0 : s + 1;
      end
      return 1'b0;
   endfunction

   function automatic answer_type apply_word(input logic [1:0] op, input logic [KEY_W-1:0] k,
                                             input logic signed [VALUE_W-1:0] v);
      answer_type a;
      int         idx;
      int         s;
      bit         stored;
      a.status = ST_NOT_FOUND;
      a.value  = '0;
      a.slot   = '0;
      case (op)
         OP_SEARCH: begin
            if (find_live_slot(k, idx)) begin
               a.status = ST_OK;
               a.value  = slot_data[idx];
               a.slot   = idx[PORT_SLOT_W-1:0];
            end
         end
         OP_INSERT: begin
            // Duplicates are not checked; the first free or tombstoned slot wins.
            a.status = ST_FULL;
            s        = int'(k) % TABLE_SLOTS;
            stored   = 1'b0;
            for (int n = 0; n < TABLE_SLOTS && !stored; n++) begin
               if (!live[s]) begin
                  live[s]      = 1'b1;
                  tomb[s]      = 1'b0;
                  slot_keys[s] = k;
                  slot_data[s] = v;
                  a.status     = ST_OK;
                  a.slot       = s[PORT_SLOT_W-1:0];
                  stored       = 1'b1;
               end else begin
                  s = (s + 1 == TABLE_SLOTS) ? 0 : s + 1;
               end
            end
         end
         OP_DELETE: begin
            if (find_live_slot(k, idx)) begin
               a.status  = ST_OK;
               a.value   = slot_data[idx];
               a.slot    = idx[PORT_SLOT_W-1:0];
               live[idx] = 1'b0;
               tomb[idx] = 1'b1;
            end
         end
         default: ;
      endcase
      return a;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_SLOTS; i++) begin
            live[i] = 1'b0;
            tomb[i] = 1'b0;
         end
         answers_due.delete();
      end else begin
         // Answers are checked before the new word is queued, so an answer can never
         // be matched against a word accepted at the same edge.
         if (rsp_valid && rsp_ready) begin
            if (answers_due.size() == 0) begin
               report_mismatch("answer arrived with no word waiting for one");
            end else begin
               want = answers_due.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_status, want.status));
               if (rsp_value_out !== want.value)
                  report_mismatch($sformatf("value_out %0d, expected %0d",
                                            rsp_value_out, want.value));
               if (rsp_slot !== want.slot)
                  report_mismatch($sformatf("slot %0d, expected %0d", rsp_slot, want.slot));
            end
            words_back++;
         end
         if (req_valid && req_ready) begin
            want = apply_word(req_opcode, req_key, req_value_in);
            if (want.status == ST_FULL)
               fulls++;
            if (want.status == ST_OK && req_opcode != OP_INSERT)
               hits++;
            answers_due.push_back(want);
         end
      end
      fail_count  <= errors;
      outstanding <= answers_due.size();
      full_count  <= fulls;
      hit_count   <= hits;
   end

endmodule

FILE: dv/linear_probe_hash_table_tb.sv
// Top of the linear_probe_hash_table testbench: clock, reset, request stimulus and verdict.
// Depends on lpht_pkg, the block itself and lpht_table_checker, which does all checking.
`timescale 1ns / 1ps

module linear_probe_hash_table_tb;
   import lpht_pkg::*;

   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_LOOKUP, MIX_EVEN} op_mix_type;

   localparam int RANDOM_WORDS = 1900;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [1:0]                req_opcode = OP_SEARCH;
   logic [KEY_W-1:0]          req_key = '0;
   logic signed [VALUE_W-1:0] req_value_in = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [1:0]                rsp_status;
   logic signed [VALUE_W-1:0] rsp_value_out;
   logic [PORT_SLOT_W-1:0]    rsp_slot;

   int fail_count;
   int outstanding;
   int full_count;
   int hit_count;

   bit               req_burst;
   int               sent[4];
   logic [KEY_W-1:0] key_pool[16];
   logic [KEY_W-1:0] live_keys[$];

   linear_probe_hash_table uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_opcode    (req_opcode),
      .req_key       (req_key),
      .req_value_in  (req_value_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_value_out (rsp_value_out),
      .rsp_slot      (rsp_slot)
   );

   lpht_table_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_opcode    (req_opcode),
      .req_key       (req_key),
      .req_value_in  (req_value_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_value_out (rsp_value_out),
      .rsp_slot      (rsp_slot),
      .fail_count    (fail_count),
      .outstanding   (outstanding),
      .full_count    (full_count),
      .hit_count     (hit_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #6_000_000;
      $display("** linear_probe_hash_table: FAILED **");
      $finish;
   end

   // Answer side: a random stall before each word, bursts without stalls, and one
   // long hold-off that lets the request side back up.
   initial begin : receiver
      int  stall;
      int  taken;
      bit  rsp_burst;
      taken     = 0;
      rsp_burst = 1'b0;
      @(posedge clock);
      while (reset)
         @(posedge clock);
      forever begin
         if (taken % 97 == 0)
            rsp_burst = ($urandom_range(0, 3) == 0);
         stall = rsp_burst ? 0 : $urandom_range(0, 13);
         if (taken == 400)
            stall = 300;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         taken++;
      end
   end

   task automatic send_word(input logic [1:0] op, input logic [KEY_W-1:0] k,
                            input logic signed [VALUE_W-1:0] v);
      int gap;
      gap = req_burst ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_opcode   <= op;
      req_key      <= k;
      req_value_in <= v;
      do @(posedge clock); while (!(req_valid && req_ready));
      sent[op]++;
   endtask

   // Stops offering words until every answer owed has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   function automatic logic [1:0] draw_op(input op_mix_type mix);
      int r;
      int ins;
      int del;
      r = $urandom_range(0, 99);
      case (mix)
         MIX_FILL:   begin ins = 70; del = 10; end
         MIX_DRAIN:  begin ins = 10; del = 65; end
         MIX_LOOKUP: begin ins = 20; del = 18; end
         default:    begin ins = 35; del = 30; end
      endcase
      if (r < 2)
         return OP_NONE;
      if (r < 2 + ins)
         return OP_INSERT;
      if (r < 2 + ins + del)
         return OP_DELETE;
      return OP_SEARCH;
   endfunction

   // Keys come mostly from a pool, ten of whose home slots crowd together, or from keys
   // inserted before, so probe chains grow long and wrap; the rest are fully random.
   function automatic logic [KEY_W-1:0] draw_key(input logic [1:0] op);
      int r;
      int idx;
      logic [KEY_W-1:0] k;
      r = $urandom_range(0, 99);
      k = KEY_W'($urandom_range(0, 65535));
      case (op)
         OP_INSERT: begin
            if (r < 85)
               k = key_pool[$urandom_range(0, 15)];
            if (live_keys.size() >= 80)
               live_keys.delete(0);
            live_keys.push_back(k);
         end
         OP_DELETE: begin
            if (r < 75 && live_keys.size() > 0) begin
               idx = $urandom_range(0, live_keys.size() - 1);
               k   = live_keys[idx];
               live_keys.delete(idx);
            end else if (r < 90) begin
               k = key_pool[$urandom_range(0, 15)];
            end
         end
         OP_SEARCH: begin
            if (r < 50 && live_keys.size() > 0)
               k = live_keys[$urandom_range(0, live_keys.size() - 1)];
            else if (r < 80)
               k = key_pool[$urandom_range(0, 15)];
         end
         default: ;
      endcase
      return k;
   endfunction

   initial begin : stimulus
      int          base;
      int          home;
      int          total;
      int          len;
      op_mix_type  mix;
      logic [1:0]  op;
      base = $urandom_range(0, TABLE_SLOTS - 1);
      for (int i = 0; i < 16; i++) begin
         home        = (i < 10) ? (base + i % 4) % TABLE_SLOTS : $urandom_range(0, 31);
         key_pool[i] = KEY_W'($urandom_range(0, 2047) * TABLE_SLOTS + home);
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: empty table, extreme keys and data, collisions, wrap from the
      // last slot, duplicates, tombstone skipping and reuse, and the unused opcode.
      req_burst = 1'b0;
      send_word(OP_SEARCH, 16'd0, 32'sd7);
      send_word(OP_DELETE, 16'd0, 32'sd0);
      send_word(OP_INSERT, 16'd0, 32'sh7FFF_FFFF);
      send_word(OP_INSERT, 16'hFFFF, 32'sh8000_0000);
      send_word(OP_INSERT, 16'd32, 32'sd1);
      send_word(OP_INSERT, 16'hFFFF, -32'sd1);
      send_word(OP_SEARCH, 16'hFFFF, 32'sd0);
      send_word(OP_SEARCH, 16'd32, 32'sd0);
      send_word(OP_DELETE, 16'd0, 32'sh7FFF_FFFF);
      send_word(OP_SEARCH, 16'd32, 32'sd0);
      send_word(OP_SEARCH, 16'd0, 32'sd0);
      send_word(OP_INSERT, 16'd64, 32'sd0);
      send_word(OP_DELETE, 16'hFFFF, 32'sd0);
      send_word(OP_SEARCH, 16'hFFFF, 32'sd0);
      send_word(OP_NONE, 16'hFFFF, -32'sd1);
      send_word(OP_INSERT, 16'd31, 32'sh5555_5555);
      send_word(OP_DELETE, 16'd12345, 32'sd0);
      send_word(OP_SEARCH, 16'd31, 32'sh2AAA_AAAA);
      wait_drained();
      live_keys.push_back(16'd32);
      live_keys.push_back(16'hFFFF);
      live_keys.push_back(16'd64);
      live_keys.push_back(16'd31);

      // Random part in blocks, each with its own blend of operations; the first block
      // is weighted toward inserts so that the table fills.
      total = 0;
      mix   = MIX_FILL;
      while (total < RANDOM_WORDS) begin
         len       = $urandom_range(60, 140);
         req_burst = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < len; i++) begin
            op = draw_op(mix);
            send_word(op, draw_key(op), $urandom);
         end
         total += len;
         if ($urandom_range(0, 1) == 0)
            wait_drained();
         mix = op_mix_type'($urandom_range(0, 3));
      end

      wait_drained();
      repeat (TABLE_SLOTS + 20) @(posedge clock);
      $display("Run sent %0d searches, %0d inserts, %0d deletes and %0d no-op words.",
               sent[OP_SEARCH], sent[OP_INSERT], sent[OP_DELETE], sent[OP_NONE]);
      $display("Inserts refused as table full: %0d; searches and deletes that hit: %0d.",
               full_count, hit_count);
      if (fail_count == 0 && outstanding == 0) begin
         $display("** linear_probe_hash_table: PASSED **");
      end else begin
         $display("** linear_probe_hash_table: FAILED **");
      end
      $finish;
   end

endmodule
